### sv/shti_pkg.sv
package shti_pkg;

	// Table geometry. SLOTS and MAX_NAME are powers of two.
	localparam int SLOTS    = 16;
	localparam int HALF     = 8;
	localparam int MAX_NAME = 16;

	localparam int SLOT_W = $clog2(SLOTS);
	localparam int BUF_W  = $clog2(MAX_NAME);
	localparam int LEN_W  = $clog2(MAX_NAME + 1);
	localparam int HASH_W = 32;
	localparam int TASK_W = 16;
	localparam int ENT_W  = HASH_W + TASK_W + LEN_W;
	localparam int STEP   = HALF % SLOTS;

	// Function codes.
	localparam logic FN_INSERT = 1'b0;
	localparam logic FN_LOOKUP = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_TOO_LONG  = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_CMP_RD,
		S_CMP_CHK,
		S_COPY,
		S_DONE
	} state_t;

	// Summary of a finished name from the front end.
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [LEN_W-1:0]  len;
		logic              too_long;
	} name_info_t;

	// One table entry as stored in the entry memory.
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [TASK_W-1:0] task_id;
		logic [LEN_W-1:0]  len;
	} entry_t;

endpackage

### sv/string_hash_table_insert_lookup.sv
// Open-addressing string hash table. Name bytes stream in one transaction per
// byte, one per cycle while the block is idle; the last byte yields one result
// transaction. After the last byte, each probe reads and checks the entry
// memory, a lookup name compare reads and compares the name memory per byte,
// and an insert copies its name into the name memory at one byte per cycle;
// the result is then handed to the output register once it is free. The table
// needs no clearing pass after reset: per-slot valid bits mark empty slots.
module string_hash_table_insert_lookup (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  name_byte,
	input  logic        last_byte,
	input  logic [15:0] task_handle,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] found_task,
	output logic [3:0]  slot_index
);

	shti_pkg::name_info_t       info;
	logic [shti_pkg::BUF_W-1:0] buf_idx;
	logic [7:0]                 buf_byte;

	// Hash and buffer the incoming name.
	shti_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (in_valid && in_ready),
		.name_byte (name_byte),
		.last_byte (last_byte),
		.rd_idx    (buf_idx),
		.rd_byte   (buf_byte),
		.info      (info)
	);

	// Probe, compare and update the table.
	shti_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.last_byte   (last_byte),
		.task_handle (task_handle),
		.info        (info),
		.buf_idx     (buf_idx),
		.buf_byte    (buf_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.found_task  (found_task),
		.slot_index  (slot_index)
	);

endmodule

### sv/shti_ram.sv
module shti_ram #(
	parameter int DW = 8,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// Single write port, registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/shti_front.sv
module shti_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        acc,
	input  logic [7:0]                  name_byte,
	input  logic                        last_byte,
	input  logic [shti_pkg::BUF_W-1:0]  rd_idx,
	output logic [7:0]                  rd_byte,
	output shti_pkg::name_info_t        info
);

	logic [shti_pkg::HASH_W-1:0] hash_q;
	logic [shti_pkg::LEN_W-1:0]  count_q;
	logic                        too_long_q;
	logic [7:0]                  buf_q [shti_pkg::MAX_NAME];
	logic [shti_pkg::HASH_W-1:0] sbyte;
	logic [shti_pkg::HASH_W-1:0] hash_nx;
	logic                        full;

	// Fold the signed byte into the hash: h*255 + b as (h<<8) - h + b.
	assign sbyte   = {{24{name_byte[7]}}, name_byte};
	assign hash_nx = (hash_q << 8) - hash_q + sbyte;
	assign full    = (count_q == shti_pkg::LEN_W'(shti_pkg::MAX_NAME));

	// Spread hash, length and overflow flag as they stand after this byte.
	assign info.hash     = hash_nx ^ {{16{hash_nx[31]}}, hash_nx[31:16]};
	assign info.len      = full ? count_q : count_q + 1'b1;
	assign info.too_long = too_long_q | full;

	assign rd_byte = buf_q[rd_idx];

	// Running hash, byte count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q     <= '0;
			count_q    <= '0;
			too_long_q <= 1'b0;
		end else if (acc) begin
			if (last_byte) begin
				hash_q     <= '0;
				count_q    <= '0;
				too_long_q <= 1'b0;
			end else begin
				hash_q <= hash_nx;
				if (full) begin
					too_long_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Name buffer.
	always_ff @(posedge clk) begin
		if (acc && !full) begin
			buf_q[count_q[shti_pkg::BUF_W-1:0]] <= name_byte;
		end
	end

endmodule

### sv/shti_ctrl.sv
module shti_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        func,
	input  logic                        last_byte,
	input  logic [15:0]                 task_handle,
	input  shti_pkg::name_info_t        info,
	output logic [shti_pkg::BUF_W-1:0]  buf_idx,
	input  logic [7:0]                  buf_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [15:0]                 found_task,
	output logic [3:0]                  slot_index
);

	localparam int NAW = shti_pkg::SLOT_W + shti_pkg::BUF_W;

	shti_pkg::state_t            state_q, state_d;
	logic                        func_q;
	logic [shti_pkg::TASK_W-1:0] task_q;
	logic [shti_pkg::HASH_W-1:0] hash_q;
	logic [shti_pkg::LEN_W-1:0]  len_q;
	logic [shti_pkg::SLOT_W-1:0] idx_q;
	logic [shti_pkg::SLOT_W-1:0] probe_q;
	logic [shti_pkg::BUF_W-1:0]  j_q;
	logic [shti_pkg::SLOTS-1:0]  vld_q;
	logic                        ent_vld_q;
	shti_pkg::status_t           res_status_q;
	logic [shti_pkg::TASK_W-1:0] res_task_q;
	logic [shti_pkg::SLOT_W-1:0] res_slot_q;
	logic                        out_valid_q;
	logic [2:0]                  status_q;
	logic [15:0]                 found_task_q;
	logic [3:0]                  slot_index_q;

	logic                        acc;
	logic                        occupied;
	logic                        hash_eq;
	logic                        last_probe;
	logic                        last_j;
	logic                        byte_eq;
	logic                        out_free;
	shti_pkg::entry_t            ent_rd;
	shti_pkg::entry_t            ent_wr;
	logic                        ent_we;
	logic                        ent_re;
	logic                        nm_we;
	logic                        nm_re;
	logic [7:0]                  nm_rd;
	logic [NAW-1:0]              nm_addr;

	assign acc        = in_valid && in_ready;
	assign occupied   = ent_vld_q && (ent_rd.hash != '0);
	assign hash_eq    = (ent_rd.hash == hash_q);
	assign last_probe = (probe_q == shti_pkg::SLOT_W'(shti_pkg::SLOTS - 1));
	assign last_j     = (shti_pkg::LEN_W'(j_q) == len_q - 1'b1);
	assign byte_eq    = (nm_rd == buf_byte);
	assign out_free   = !out_valid_q || out_ready;
	assign nm_addr    = {idx_q, j_q};
	assign buf_idx    = j_q;
	assign ent_wr     = '{hash: hash_q, task_id: task_q, len: len_q};

	// Entry memory: hash, task handle and name length per slot.
	shti_ram #(.DW(shti_pkg::ENT_W), .AW(shti_pkg::SLOT_W)) u_ent (
		.clk   (clk),
		.we    (ent_we),
		.waddr (idx_q),
		.wdata (ent_wr),
		.re    (ent_re),
		.raddr (idx_q),
		.rdata (ent_rd)
	);

	// Name memory: MAX_NAME bytes per slot.
	shti_ram #(.DW(8), .AW(NAW)) u_name (
		.clk   (clk),
		.we    (nm_we),
		.waddr (nm_addr),
		.wdata (buf_byte),
		.re    (nm_re),
		.raddr (nm_addr),
		.rdata (nm_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			shti_pkg::S_IDLE: begin
				if (acc && last_byte) begin
					state_d = info.too_long ? shti_pkg::S_DONE : shti_pkg::S_READ;
				end
			end
			shti_pkg::S_READ: begin
				state_d = shti_pkg::S_CHECK;
			end
			shti_pkg::S_CHECK: begin
				if (func_q == shti_pkg::FN_INSERT) begin
					if (!occupied) begin
						state_d = shti_pkg::S_COPY;
					end else begin
						state_d = last_probe ? shti_pkg::S_DONE : shti_pkg::S_READ;
					end
				end else if (!occupied) begin
					state_d = shti_pkg::S_DONE;
				end else if (hash_eq) begin
					state_d = (ent_rd.len == len_q) ? shti_pkg::S_CMP_RD : shti_pkg::S_DONE;
				end else begin
					state_d = last_probe ? shti_pkg::S_DONE : shti_pkg::S_READ;
				end
			end
			shti_pkg::S_CMP_RD: begin
				state_d = shti_pkg::S_CMP_CHK;
			end
			shti_pkg::S_CMP_CHK: begin
				state_d = (!byte_eq || last_j) ? shti_pkg::S_DONE : shti_pkg::S_CMP_RD;
			end
			shti_pkg::S_COPY: begin
				state_d = last_j ? shti_pkg::S_DONE : shti_pkg::S_COPY;
			end
			shti_pkg::S_DONE: begin
				state_d = out_free ? shti_pkg::S_IDLE : shti_pkg::S_DONE;
			end
			default: begin
				state_d = shti_pkg::S_IDLE;
			end
		endcase
	end

	// Memory controls and handshake.
	always_comb begin
		in_ready = 1'b0;
		ent_re   = 1'b0;
		ent_we   = 1'b0;
		nm_re    = 1'b0;
		nm_we    = 1'b0;
		case (state_q)
			shti_pkg::S_IDLE:   in_ready = 1'b1;
			shti_pkg::S_READ:   ent_re   = 1'b1;
			shti_pkg::S_CHECK:  ent_we   = (func_q == shti_pkg::FN_INSERT) && !occupied;
			shti_pkg::S_CMP_RD: nm_re    = 1'b1;
			shti_pkg::S_COPY:   nm_we    = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// Sequencer state and slot valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= shti_pkg::S_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ent_we) begin
				vld_q[idx_q] <= 1'b1;
			end
			if (state_q == shti_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers for the current name and its result.
	always_ff @(posedge clk) begin
		case (state_q)
			shti_pkg::S_IDLE: begin
				if (acc && last_byte) begin
					func_q     <= func;
					task_q     <= task_handle;
					hash_q     <= info.hash;
					len_q      <= info.len;
					idx_q      <= info.hash[shti_pkg::SLOT_W-1:0];
					probe_q    <= '0;
					j_q        <= '0;
					res_task_q <= '0;
					res_slot_q <= '0;
					if (info.too_long) begin
						res_status_q <= shti_pkg::ST_TOO_LONG;
					end else if (func == shti_pkg::FN_INSERT) begin
						res_status_q <= shti_pkg::ST_FULL;
					end else begin
						res_status_q <= shti_pkg::ST_NOT_FOUND;
					end
				end
			end
			shti_pkg::S_READ: begin
				ent_vld_q <= vld_q[idx_q];
			end
			shti_pkg::S_CHECK: begin
				// Step to the next slot only when the probe goes on; a lookup
				// that hits an equal hash keeps the slot for the name compare.
				if (func_q == shti_pkg::FN_INSERT && !occupied) begin
					res_status_q <= shti_pkg::ST_INSERTED;
					res_slot_q   <= idx_q;
				end else if (occupied && !(func_q == shti_pkg::FN_LOOKUP && hash_eq)) begin
					idx_q   <= idx_q + shti_pkg::SLOT_W'(shti_pkg::STEP)
						+ shti_pkg::SLOT_W'(probe_q[0]);
					probe_q <= probe_q + 1'b1;
				end
			end
			shti_pkg::S_CMP_CHK: begin
				if (byte_eq && last_j) begin
					res_status_q <= shti_pkg::ST_FOUND;
					res_task_q   <= ent_rd.task_id;
					res_slot_q   <= idx_q;
				end
				j_q <= j_q + 1'b1;
			end
			shti_pkg::S_COPY: begin
				j_q <= j_q + 1'b1;
			end
			shti_pkg::S_DONE: begin
				if (out_free) begin
					status_q     <= res_status_q;
					found_task_q <= res_task_q;
					slot_index_q <= 4'(res_slot_q);
				end
			end
			default: begin
				j_q <= j_q;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign found_task = found_task_q;
	assign slot_index = slot_index_q;

endmodule

### sv/shti_chk.sv
module shti_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] found_task,
	input logic [3:0]  slot_index
);

	// A pending result transaction stays until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result dropped before transaction");

	// Status of a valid result is always a defined code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= shti_pkg::ST_TOO_LONG)
		else $error("undefined status");

	// A task handle is only reported with a found status.
	a_task: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != shti_pkg::ST_FOUND |-> found_task == 16'd0)
		else $error("task handle without match");

	// A slot is only reported for inserted or found.
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != shti_pkg::ST_INSERTED && status != shti_pkg::ST_FOUND
		|-> slot_index == 4'd0)
		else $error("slot index without slot");

endmodule

bind string_hash_table_insert_lookup shti_chk u_shti_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.found_task (found_task),
	.slot_index (slot_index)
);

### tb/tb_string_hash_table_insert_lookup.sv
`timescale 1ns / 1ps

module tb_string_hash_table_insert_lookup;

	// One name byte as offered to the block.
	typedef struct {
		logic        fn;
		logic [7:0]  nbyte;
		logic        lastb;
		logic [15:0] handle;
	} byte_item_t;

	// One result as returned by the block.
	typedef struct {
		shti_pkg::status_t st;
		logic [15:0]       ftask;
		logic [3:0]        sidx;
	} table_result_t;

	localparam int LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [7:0]  name_byte;
	logic        last_byte;
	logic [15:0] task_handle;
	logic        out_valid;
	logic        out_ready;
	logic [2:0]  status;
	logic [15:0] found_task;
	logic [3:0]  slot_index;

	// Predictor state: a private copy of the table.
	logic [31:0] tbl_hash [shti_pkg::SLOTS];
	logic [15:0] tbl_task [shti_pkg::SLOTS];
	logic [7:0]  tbl_name [shti_pkg::SLOTS][shti_pkg::MAX_NAME];
	int          tbl_len  [shti_pkg::SLOTS];
	logic [7:0]  name_acc [shti_pkg::MAX_NAME];
	logic [31:0] hash_acc;
	int          name_cnt;
	bit          overlong;

	byte_item_t    pending_bytes[$];
	table_result_t expected_results[$];
	byte_item_t    name_bytes[$];
	int            send_idle_pct;
	int            recv_stall_pct;
	int            hold_cycles;
	int            fail_count;
	int            cycle_count;

	string_hash_table_insert_lookup u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .name_byte(name_byte), .last_byte(last_byte),
		.task_handle(task_handle), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_task(found_task), .slot_index(slot_index)
	);

	always #10 clk = ~clk;

	// Fold one accepted byte into the predicted table and queue any result.
	task automatic predict_byte(input byte_item_t it);
		logic [31:0] sx;
		logic [31:0] spread;
		int idx;
		table_result_t r;
		bit same;
		sx = {{24{it.nbyte[7]}}, it.nbyte};
		hash_acc = hash_acc * 32'd255 + sx;
		if (name_cnt < shti_pkg::MAX_NAME) begin
			name_acc[name_cnt] = it.nbyte;
			name_cnt++;
		end else begin
			overlong = 1;
		end
		if (!it.lastb)
			return;
		spread = hash_acc ^ {{16{hash_acc[31]}}, hash_acc[31:16]};
		idx = spread % shti_pkg::SLOTS;
		r.st = shti_pkg::ST_NOT_FOUND;
		r.ftask = '0;
		r.sidx = '0;
		if (overlong) begin
			r.st = shti_pkg::ST_TOO_LONG;
		end else if (it.fn == shti_pkg::FN_INSERT) begin
			r.st = shti_pkg::ST_FULL;
			for (int i = 0; i < shti_pkg::SLOTS; i++) begin
				if (tbl_hash[idx] == 0) begin
					tbl_hash[idx] = spread;
					tbl_task[idx] = it.handle;
					tbl_len[idx] = name_cnt;
					for (int j = 0; j < name_cnt; j++)
						tbl_name[idx][j] = name_acc[j];
					r.st = shti_pkg::ST_INSERTED;
					r.sidx = idx;
					break;
				end
				idx = (idx + shti_pkg::HALF + (i & 1)) % shti_pkg::SLOTS;
			end
		end else begin
			for (int i = 0; i < shti_pkg::SLOTS; i++) begin
				if (tbl_hash[idx] == 0)
					break;
				if (tbl_hash[idx] == spread) begin
					same = (tbl_len[idx] == name_cnt);
					for (int j = 0; j < name_cnt; j++)
						if (same && tbl_name[idx][j] != name_acc[j])
							same = 0;
					if (same) begin
						r.st = shti_pkg::ST_FOUND;
						r.ftask = tbl_task[idx];
						r.sidx = idx;
					end
					break;
				end
				idx = (idx + shti_pkg::HALF + (i & 1)) % shti_pkg::SLOTS;
			end
		end
		hash_acc = '0;
		name_cnt = 0;
		overlong = 0;
		expected_results.push_back(r);
	endtask

	// Queue one whole name as byte transactions.
	task automatic queue_name(input logic fn, input byte_item_t nm[$], input logic [15:0] h);
		byte_item_t it;
		foreach (nm[k]) begin
			it = nm[k];
			it.fn = $urandom_range(0, 1);
			it.handle = $urandom;
			it.lastb = (k == nm.size() - 1);
			if (it.lastb) begin
				it.fn = fn;
				it.handle = h;
			end
			pending_bytes.push_back(it);
		end
	endtask

	// Build a random name of the given length from a small or full alphabet.
	task automatic make_name(input int len, input bit narrow, output byte_item_t nm[$]);
		byte_item_t it;
		nm = {};
		for (int k = 0; k < len; k++) begin
			it.nbyte = narrow ? 8'(97 + $urandom_range(0, 2)) : 8'($urandom);
			nm.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// Driver: offers pending bytes, holding each until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= 1'b0;
			name_byte <= '0;
			last_byte <= 1'b0;
			task_handle <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(pending_bytes.pop_front());
			end
			if ((!in_valid || in_ready) ) begin
				if (pending_bytes.size() > (in_valid && in_ready ? 0 : 0) &&
				    $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					func <= pending_bytes[0].fn;
					name_byte <= pending_bytes[0].nbyte;
					last_byte <= pending_bytes[0].lastb;
					task_handle <= pending_bytes[0].handle;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		table_result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d", status);
					fail_count++;
				end else begin
					e = expected_results.pop_front();
					if (status !== e.st) begin
						$error("status: expected %0d, actual %0d", e.st, status);
						fail_count++;
					end
					if (found_task !== e.ftask) begin
						$error("found_task: expected %0h, actual %0h", e.ftask, found_task);
						fail_count++;
					end
					if (slot_index !== e.sidx) begin
						$error("slot_index: expected %0d, actual %0d", e.sidx, slot_index);
						fail_count++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("string_hash_table_insert_lookup test failed");
			$finish;
		end
	end

	// Stimulus, phases and the final verdict.
	initial begin
		byte_item_t nm[$];
		byte_item_t one;
		int len;
		clk = 0;
		arst_n = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		fail_count = 0;
		cycle_count = 0;
		hash_acc = '0;
		name_cnt = 0;
		overlong = 0;
		for (int s = 0; s < shti_pkg::SLOTS; s++)
			tbl_hash[s] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// Directed: lookups on an empty table, inserts and lookups of extreme bytes, full-length and overlong names.
		one.nbyte = 8'h00; nm = {one};
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'hFFFF);
		queue_name(shti_pkg::FN_INSERT, nm, 16'hFFFF);
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h0000);
		one.nbyte = 8'hFF; nm = {one, one};
		queue_name(shti_pkg::FN_INSERT, nm, 16'h0000);
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h1234);
		one.nbyte = 8'h80; nm = {one};
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h0);
		one.nbyte = 8'h7F; nm = {one};
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h0);
		make_name(shti_pkg::MAX_NAME, 0, nm);
		queue_name(shti_pkg::FN_INSERT, nm, 16'hA5A5);
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h0);
		make_name(shti_pkg::MAX_NAME + 1, 0, nm);
		queue_name(shti_pkg::FN_INSERT, nm, 16'h5A5A);
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h0);
		// Duplicate inserts of one name.
		make_name(3, 1, nm);
		queue_name(shti_pkg::FN_INSERT, nm, 16'h0101);
		queue_name(shti_pkg::FN_INSERT, nm, 16'h0202);
		queue_name(shti_pkg::FN_LOOKUP, nm, 16'h0);
		wait_drained();

		// Random phases; each mixes inserts that fill the table well past full with lookups of names.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 76; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 76; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			if (ph == 0)
				hold_cycles = 400;
			for (int n = 0; n < 120; n++) begin
				len = ($urandom_range(0, 19) == 0)
					? $urandom_range(shti_pkg::MAX_NAME - 1, shti_pkg::MAX_NAME + 2)
					: $urandom_range(1, 3);
				make_name(len, $urandom_range(0, 3) != 0, nm);
				if ($urandom_range(0, 2) == 0 && name_bytes.size() != 0) begin
					// Look up a name that was offered before.
					queue_name(shti_pkg::FN_LOOKUP, name_bytes, $urandom);
				end else begin
					queue_name(logic'($urandom_range(0, 1)), nm, $urandom);
					name_bytes = nm;
				end
			end
			wait_drained();
		end
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("string_hash_table_insert_lookup test passed");
		else
			$display("string_hash_table_insert_lookup test failed");
		$finish;
	end

endmodule
